@@ rtl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants and types of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	typedef enum logic [2:0] {
		ACT_ADD  = 3'd0,
		ACT_SUB  = 3'd1,
		ACT_CONJ = 3'd2,
		ACT_MAG  = 3'd3,
		ACT_MUL  = 3'd4,
		ACT_DIV  = 3'd5
	} cau_action_t;

	typedef struct packed {
		logic is_div;
		logic dz;
		logic big_re;
		logic big_im;
		logic neg_re;
		logic neg_im;
	} cau_flags_t;

endpackage

@@ rtl/cau_div.sv @@
// ----------------------------------------------------------------------------
// cau_div
// Restoring divider, one quotient bit per stage, two lanes sharing a divisor.
// Items that are not divides ride through with their value in the remainder.
// ----------------------------------------------------------------------------
module cau_div #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS,
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2*WORD_BITS:0]        in_re,
	input  logic [2*WORD_BITS:0]        in_im,
	input  logic [2*WORD_BITS-1:0]      in_den,
	input  cau_pkg::cau_flags_t         in_flags,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2*WORD_BITS:0]        out_rem_re,
	output logic [2*WORD_BITS:0]        out_rem_im,
	output logic [WORD_BITS:0]          out_q_re,
	output logic [WORD_BITS:0]          out_q_im,
	output cau_pkg::cau_flags_t         out_flags
);

	localparam int S  = 2 * WORD_BITS + 1;
	localparam int QB = WORD_BITS + 1;
	localparam int RW = 2 * WORD_BITS + QB + FRAC_BITS + 2;

	logic [RW-1:0]          rem_re_s [0:QB];
	logic [RW-1:0]          rem_im_s [0:QB];
	logic [QB-1:0]          q_re_s   [0:QB];
	logic [QB-1:0]          q_im_s   [0:QB];
	logic [2*WORD_BITS-1:0] den_s    [0:QB];
	cau_pkg::cau_flags_t    flg_s    [0:QB];
	logic                   v_s      [0:QB];
	logic                   rdy      [0:QB+1];

	logic [S-1:0]  mag_re, mag_im;
	logic [RW-1:0] x_re, x_im, dtop;
	cau_pkg::cau_flags_t f0;

	assign rdy[QB+1] = out_ready;
	assign in_ready  = rdy[0];
	assign rdy[0]    = !v_s[0] || rdy[1];

	always_comb begin
		mag_re    = in_re[S-1] ? (~in_re + S'(1)) : in_re;
		mag_im    = in_im[S-1] ? (~in_im + S'(1)) : in_im;
		x_re      = RW'(mag_re) << FRAC_BITS;
		x_im      = RW'(mag_im) << FRAC_BITS;
		dtop      = RW'(in_den) << QB;
		f0        = in_flags;
		f0.neg_re = in_re[S-1];
		f0.neg_im = in_im[S-1];
		f0.big_re = in_flags.is_div && !in_flags.dz && (x_re >= dtop);
		f0.big_im = in_flags.is_div && !in_flags.dz && (x_im >= dtop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			rem_re_s[0] <= in_flags.is_div ? x_re : RW'(in_re);
			rem_im_s[0] <= in_flags.is_div ? x_im : RW'(in_im);
			q_re_s[0]   <= '0;
			q_im_s[0]   <= '0;
			den_s[0]    <= in_den;
			flg_s[0]    <= f0;
		end
	end

	for (genvar i = 1; i <= QB; i++) begin : g_step
		localparam int K = QB - i;
		logic [RW-1:0] dsh, nrem_re, nrem_im;
		logic [QB-1:0] nq_re, nq_im;
		logic          go_re, go_im;

		assign rdy[i] = !v_s[i] || rdy[i+1];

		always_comb begin
			dsh     = RW'(den_s[i-1]) << K;
			go_re   = flg_s[i-1].is_div && !flg_s[i-1].dz && !flg_s[i-1].big_re
			          && (rem_re_s[i-1] >= dsh);
			go_im   = flg_s[i-1].is_div && !flg_s[i-1].dz && !flg_s[i-1].big_im
			          && (rem_im_s[i-1] >= dsh);
			nrem_re = go_re ? (rem_re_s[i-1] - dsh) : rem_re_s[i-1];
			nrem_im = go_im ? (rem_im_s[i-1] - dsh) : rem_im_s[i-1];
			nq_re   = q_re_s[i-1];
			nq_im   = q_im_s[i-1];
			nq_re[K] = go_re;
			nq_im[K] = go_im;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				v_s[i] <= v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && v_s[i-1]) begin
				rem_re_s[i] <= nrem_re;
				rem_im_s[i] <= nrem_im;
				q_re_s[i]   <= nq_re;
				q_im_s[i]   <= nq_im;
				den_s[i]    <= den_s[i-1];
				flg_s[i]    <= flg_s[i-1];
			end
		end
	end

	assign out_valid  = v_s[QB];
	assign out_rem_re = rem_re_s[QB][S-1:0];
	assign out_rem_im = rem_im_s[QB][S-1:0];
	assign out_q_re   = q_re_s[QB];
	assign out_q_im   = q_im_s[QB];
	assign out_flags  = flg_s[QB];

endmodule

@@ rtl/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Saturating fixed-point complex add, subtract, conjugate, magnitude squared,
// multiply and divide on a valid/ready stream.
// ----------------------------------------------------------------------------
// Accepts one item per cycle while the output is not stalled and returns one
// result per item, in order. The divider resolves one quotient bit per
// pipeline stage; every action travels the same pipeline, so the results
// never reorder. Bubbles inside the pipeline are squeezed out when the output
// stalls.
module complex_arithmetic_unit #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS,
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  action,
	input  logic signed [WORD_BITS-1:0] a_re,
	input  logic signed [WORD_BITS-1:0] a_im,
	input  logic signed [WORD_BITS-1:0] b_re,
	input  logic signed [WORD_BITS-1:0] b_im,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [WORD_BITS-1:0] res_re,
	output logic signed [WORD_BITS-1:0] res_im,
	output logic                        overflow,
	output logic                        divide_by_zero
);

	localparam int W  = WORD_BITS;
	localparam int S  = 2 * W + 1;
	localparam int QB = W + 1;

	function automatic logic [W:0] sat(input logic [S-1:0] x);
		logic [S-W:0] hi;
		hi = x[S-1:W-1];
		if ((&hi) || !(|hi)) begin
			return {1'b0, x[W-1:0]};
		end
		return x[S-1] ? {1'b1, 1'b1, {(W-1){1'b0}}} : {1'b1, 1'b0, {(W-1){1'b1}}};
	endfunction

	// stage 1: input register
	logic                v_s1, rdy1;
	logic [2:0]          act_s1;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	// stage 2: products
	logic                  v_s2, rdy2;
	logic [2:0]            act_s2;
	logic signed [W-1:0]   ar_s2, ai_s2, br_s2, bi_s2;
	logic signed [2*W-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;

	// stage 3: sums
	logic                v_s3, rdy3;
	logic [S-1:0]        re_s3, im_s3;
	logic [2*W-1:0]      den_s3;
	cau_pkg::cau_flags_t flg_s3;

	// divider
	logic                div_ready, dv_valid, dv_ready;
	logic [S-1:0]        dv_rem_re, dv_rem_im;
	logic [QB-1:0]       dv_q_re, dv_q_im;
	cau_pkg::cau_flags_t dv_flags;

	// output stage
	logic                v_q;
	logic signed [W-1:0] res_re_q, res_im_q;
	logic                ov_q, dz_q;

	assign rdy1     = !v_s1 || rdy2;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy3     = !v_s3 || div_ready;
	assign dv_ready = !v_q || out_ready;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (dv_ready) v_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			act_s1 <= action;
			ar_s1  <= a_re;
			ai_s1  <= a_im;
			br_s1  <= b_re;
			bi_s1  <= b_im;
		end
	end

	logic signed [W-1:0] m0b, m1b;

	always_comb begin
		m0b = (act_s1 == cau_pkg::ACT_MAG) ? ar_s1 : br_s1;
		m1b = (act_s1 == cau_pkg::ACT_MAG) ? ai_s1 : bi_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			act_s2 <= act_s1;
			ar_s2  <= ar_s1;
			ai_s2  <= ai_s1;
			br_s2  <= br_s1;
			bi_s2  <= bi_s1;
			p0_s2  <= ar_s1 * m0b;
			p1_s2  <= ai_s1 * m1b;
			p2_s2  <= ar_s1 * bi_s1;
			p3_s2  <= ai_s1 * br_s1;
			p4_s2  <= br_s1 * br_s1;
			p5_s2  <= bi_s1 * bi_s1;
		end
	end

	logic signed [S-1:0] xar, xai, xbr, xbi, e0, e1, e2, e3, nre, nim;
	logic [2*W-1:0]      nden;
	cau_pkg::cau_flags_t nflg;

	always_comb begin
		xar  = S'(ar_s2);
		xai  = S'(ai_s2);
		xbr  = S'(br_s2);
		xbi  = S'(bi_s2);
		e0   = S'(p0_s2);
		e1   = S'(p1_s2);
		e2   = S'(p2_s2);
		e3   = S'(p3_s2);
		nden = p4_s2 + p5_s2;
		nflg = '0;
		nre  = '0;
		nim  = '0;
		case (act_s2)
			cau_pkg::ACT_ADD: begin
				nre = xar + xbr;
				nim = xai + xbi;
			end
			cau_pkg::ACT_SUB: begin
				nre = xar - xbr;
				nim = xai - xbi;
			end
			cau_pkg::ACT_CONJ: begin
				nre = xar;
				nim = -xai;
			end
			cau_pkg::ACT_MAG: begin
				nre = (e0 + e1) >>> FRAC_BITS;
			end
			cau_pkg::ACT_MUL: begin
				nre = (e0 - e1) >>> FRAC_BITS;
				nim = (e2 + e3) >>> FRAC_BITS;
			end
			cau_pkg::ACT_DIV: begin
				nre         = e0 + e1;
				nim         = e3 - e2;
				nflg.is_div = 1'b1;
				nflg.dz     = (nden == '0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			re_s3  <= nre;
			im_s3  <= nim;
			den_s3 <= nden;
			flg_s3 <= nflg;
		end
	end

	cau_div #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (div_ready),
		.in_re     (re_s3),
		.in_im     (im_s3),
		.in_den    (den_s3),
		.in_flags  (flg_s3),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_rem_re(dv_rem_re),
		.out_rem_im(dv_rem_im),
		.out_q_re  (dv_q_re),
		.out_q_im  (dv_q_im),
		.out_flags (dv_flags)
	);

	logic [W:0]   sr, si;
	logic [S-1:0] qr, qi;

	always_comb begin
		qr = S'(dv_q_re);
		qi = S'(dv_q_im);
		if (dv_flags.neg_re) qr = ~qr + S'(1);
		if (dv_flags.neg_im) qi = ~qi + S'(1);
		if (!dv_flags.is_div) begin
			sr = sat(dv_rem_re);
			si = sat(dv_rem_im);
		end else if (dv_flags.dz) begin
			sr = '0;
			si = '0;
		end else begin
			sr = dv_flags.big_re ? sat({dv_flags.neg_re, {(S-1){!dv_flags.neg_re}}}) : sat(qr);
			si = dv_flags.big_im ? sat({dv_flags.neg_im, {(S-1){!dv_flags.neg_im}}}) : sat(qi);
		end
	end

	always_ff @(posedge clk) begin
		if (dv_ready && dv_valid) begin
			res_re_q <= sr[W-1:0];
			res_im_q <= si[W-1:0];
			ov_q     <= sr[W] | si[W];
			dz_q     <= dv_flags.is_div & dv_flags.dz;
		end
	end

	assign out_valid      = v_q;
	assign res_re         = res_re_q;
	assign res_im         = res_im_q;
	assign overflow       = ov_q;
	assign divide_by_zero = dz_q;

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> res_re == '0 && res_im == '0 && !overflow)
		else $error("divide by zero with nonzero result");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(overflow && divide_by_zero))
		else $error("overflow and divide by zero together");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without an output stall");

	a_div_path: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid && !dv_flags.is_div |-> !dv_flags.dz && !dv_flags.big_re && !dv_flags.big_im)
		else $error("divide flags on a non-divide item");

endmodule

@@ tb/tb_complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Self-checking bench for the complex arithmetic unit: a directed table of
// corner items then random items, each checked against a typed result or an
// exact wide-integer prediction, under random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = cau_pkg::WORD_BITS;
	localparam int FB = cau_pkg::FRAC_BITS;
	localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ONE  = 1 <<< FB;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic [2:0]          act;
		logic signed [W-1:0] ar, ai, br, bi;
	} cplx_op_t;

	typedef struct {
		logic signed [W-1:0] re, im;
		logic                ov, dz;
	} cplx_res_t;

	typedef struct {
		cplx_op_t  op;
		logic      typed;
		cplx_res_t res;
	} stim_row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [2:0] action;
	logic signed [W-1:0] a_re, a_im, b_re, b_im, res_re, res_im;
	logic overflow, divide_by_zero;

	logic      cur_typed;
	cplx_res_t cur_typed_res;
	cplx_res_t pending_results[$];
	stim_row_t stim_table[$];
	int  errors, idle_cycles, phase, in_idle_pct, out_idle_pct;
	bit  hold_done;

	complex_arithmetic_unit u_dut (.*);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	function automatic logic signed [W-1:0] clamp(input logic signed [127:0] v,
		inout logic ov);
		if (v > 128'(MAXV)) begin
			ov = 1'b1;
			return MAXV;
		end
		if (v < 128'sd0 + MINV) begin
			ov = 1'b1;
			return MINV;
		end
		return v[W-1:0];
	endfunction

	function automatic cplx_res_t compute_result(cplx_op_t op);
		logic signed [127:0] ar, ai, br, bi, re, im, den;
		cplx_res_t r;
		logic ov;
		ar = op.ar; ai = op.ai; br = op.br; bi = op.bi;
		re = 0; im = 0;
		ov = 1'b0;
		r.dz = 1'b0;
		case (op.act)
			cau_pkg::ACT_ADD: begin re = ar + br; im = ai + bi; end
			cau_pkg::ACT_SUB: begin re = ar - br; im = ai - bi; end
			cau_pkg::ACT_CONJ: begin re = ar; im = -ai; end
			cau_pkg::ACT_MAG: re = (ar * ar + ai * ai) >>> FB;
			cau_pkg::ACT_MUL: begin
				re = (ar * br - ai * bi) >>> FB;
				im = (ar * bi + ai * br) >>> FB;
			end
			cau_pkg::ACT_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.dz = 1'b1;
				end else begin
					re = ((ar * br + ai * bi) <<< FB) / den;
					im = ((ai * br - ar * bi) <<< FB) / den;
				end
			end
			default: ;
		endcase
		r.re = clamp(re, ov);
		r.im = clamp(im, ov);
		r.ov = ov;
		return r;
	endfunction

	always @(posedge clk) begin
		cplx_res_t e;
		cplx_op_t  op;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result with no item pending");
					errors++;
				end else begin
					e = pending_results.pop_front();
					if (res_re !== e.re) begin
						$error("res_re expected %h got %h", e.re, res_re); errors++;
					end
					if (res_im !== e.im) begin
						$error("res_im expected %h got %h", e.im, res_im); errors++;
					end
					if (overflow !== e.ov) begin
						$error("overflow expected %b got %b", e.ov, overflow); errors++;
					end
					if (divide_by_zero !== e.dz) begin
						$error("divide_by_zero expected %b got %b", e.dz, divide_by_zero);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				op.act = action; op.ar = a_re; op.ai = a_im; op.br = b_re; op.bi = b_im;
				pending_results.push_back(cur_typed ? cur_typed_res : compute_result(op));
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("** complex_arithmetic_unit: FAILED **");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		int hold;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (phase == 2 && !hold_done) begin
			out_ready <= 1'b0;
			for (hold = 0; hold < 400; hold++) @(negedge clk);
			hold_done = 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	task automatic add_row(logic [2:0] act, logic signed [W-1:0] ar, ai, br, bi,
		logic typed = 1'b0, logic signed [W-1:0] re = 0, im = 0, logic ov = 0, dz = 0);
		stim_row_t s;
		s.op.act = act; s.op.ar = ar; s.op.ai = ai; s.op.br = br; s.op.bi = bi;
		s.typed = typed;
		s.res.re = re; s.res.im = im; s.res.ov = ov; s.res.dz = dz;
		stim_table.push_back(s);
	endtask

	task automatic send(cplx_op_t op, logic typed, cplx_res_t tres);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= op.act; a_re <= op.ar; a_im <= op.ai; b_re <= op.br; b_im <= op.bi;
		cur_typed <= typed; cur_typed_res <= tres;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [W-1:0] rand_part(int kind);
		case (kind)
			0: return $urandom;
			1: return W'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
			2: return W'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
			3: return ($urandom_range(1)) ? MAXV : MINV;
			default: return W'($signed($urandom_range(0, 8)) - 4);
		endcase
	endfunction

	initial begin
		cplx_op_t  op;
		cplx_res_t none;
		int n, kind;
		arst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0;
		action = cau_pkg::ACT_ADD; a_re = 0; a_im = 0; b_re = 0; b_im = 0;
		cur_typed = 1'b0; cur_typed_res = '{default: 0};
		none = '{default: 0};
		errors = 0; idle_cycles = 0; phase = 0; hold_done = 1'b0;
		in_idle_pct = 17; out_idle_pct = 79;

		add_row(cau_pkg::ACT_ADD, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(cau_pkg::ACT_ADD, MAXV, MAXV, MAXV, MAXV, 1, MAXV, MAXV, 1, 0);
		add_row(cau_pkg::ACT_ADD, MINV, MINV, MINV, MINV, 1, MINV, MINV, 1, 0);
		add_row(cau_pkg::ACT_SUB, MINV, MAXV, 1, -1, 1, MINV, MAXV, 1, 0);
		add_row(cau_pkg::ACT_SUB, ONE, -ONE, ONE, ONE);
		add_row(cau_pkg::ACT_CONJ, MAXV, MINV, 0, 0, 1, MAXV, MAXV, 1, 0);
		add_row(cau_pkg::ACT_CONJ, MINV, MAXV, 0, 0, 1, MINV, -MAXV, 0, 0);
		add_row(cau_pkg::ACT_MAG, ONE, ONE, 0, 0, 1, 2 * ONE, 0, 0, 0);
		add_row(cau_pkg::ACT_MAG, MINV, MINV, 0, 0, 1, MAXV, 0, 1, 0);
		add_row(cau_pkg::ACT_MAG, -1, 0, 0, 0);
		add_row(cau_pkg::ACT_MUL, ONE, 0, MINV, MAXV);
		add_row(cau_pkg::ACT_MUL, MAXV, MINV, MAXV, MINV);
		add_row(cau_pkg::ACT_MUL, -1, -1, 1, 1);
		add_row(cau_pkg::ACT_DIV, MAXV, MINV, 0, 0, 1, 0, 0, 0, 1);
		add_row(cau_pkg::ACT_DIV, ONE, ONE, ONE, 0, 1, ONE, ONE, 0, 0);
		add_row(cau_pkg::ACT_DIV, -ONE, 3, 0, 7);
		add_row(cau_pkg::ACT_DIV, MAXV, MAXV, 1, 0);
		add_row(cau_pkg::ACT_DIV, MINV, MAXV, MINV, MINV);
		add_row(cau_pkg::ACT_DIV, -5, 9, 1, -1);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_table[i])
			send(stim_table[i].op, stim_table[i].typed, stim_table[i].res);

		for (n = 0; n < 1500; n++) begin
			if (n == 500) begin
				in_idle_pct = 79; out_idle_pct = 17; phase = 1;
			end
			if (n == 1000) begin
				in_valid <= 1'b0;
				while (pending_results.size() != 0) @(negedge clk);
				in_idle_pct = 0; out_idle_pct = 0; phase = 2;
			end
			kind = $urandom_range(4);
			op.act = cau_pkg::cau_action_t'($urandom_range(cau_pkg::ACT_DIV));
			op.ar = rand_part(kind); op.ai = rand_part(kind);
			op.br = rand_part($urandom_range(4)); op.bi = rand_part(kind);
			if (op.act == cau_pkg::ACT_DIV && $urandom_range(19) == 0) begin
				op.br = 0; op.bi = 0;
			end
			send(op, 1'b0, none);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (2 * W + 20) @(posedge clk);
		if (errors == 0)
			$display("** complex_arithmetic_unit: PASSED **");
		else
			$display("** complex_arithmetic_unit: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/cau_pkg.sv
rtl/cau_div.sv
rtl/complex_arithmetic_unit.sv
tb/tb_complex_arithmetic_unit.sv
